FILE: rtl/jdnc_pkg.sv
// Package with the constants and lookup tables of the Julian day number converter.
package jdnc_pkg;

    localparam int STAGES = 8;

    localparam logic [22:0] JDN_MIN  = 23'd1721060;
    localparam logic [22:0] JDN_MAX  = 23'd5373484;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic        REQ_DATE_TO_JDN = 1'b0;
    localparam logic        REQ_JDN_TO_DATE = 1'b1;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    // Reciprocal multipliers for division by a constant, with the shift that goes with each.
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          SHIFT_100    = 19;
    localparam logic [12:0] RECIP_146097 = 13'd7349;
    localparam int          SHIFT_146097 = 30;
    localparam logic [9:0]  RECIP_1461   = 10'd717;
    localparam int          SHIFT_1461   = 20;
    localparam logic [12:0] RECIP_153    = 13'd6854;
    localparam int          SHIFT_153    = 20;

    typedef struct packed {
        logic       req;
        logic       bad;
        logic [22:0] jdn;
    } t_carry;

    // Returns (367 * (m + 12a - 2)) / 12 for a calendar month m (January is 1), with a = 1 in January and February.
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] off;
        case (month)
            4'd1:    off = 9'd336;
            4'd2:    off = 9'd367;
            4'd3:    off = 9'd30;
            4'd4:    off = 9'd61;
            4'd5:    off = 9'd91;
            4'd6:    off = 9'd122;
            4'd7:    off = 9'd152;
            4'd8:    off = 9'd183;
            4'd9:    off = 9'd214;
            4'd10:   off = 9'd244;
            4'd11:   off = 9'd275;
            4'd12:   off = 9'd305;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Returns (153 * mm + 2) / 5, the first day of a March-based month within its year.
    function automatic logic [8:0] day_offset(input logic [3:0] mm);
        logic [8:0] off;
        case (mm)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

FILE: rtl/julian_day_number_converter.sv
// Pipelined converter between Gregorian dates and Julian day numbers.
//
//   Channel   Dir  Handshake          Payload
//   request   in   i_valid / o_stall  i_req_type, i_year_in, i_month_in, i_day_in, i_jdn_in
//   result    out  o_valid / i_stall  o_jdn_out, o_year_out, o_month_out, o_day_out, o_invalid
//
// A result becomes valid after its transaction has passed the eight register stages.
// It leaves the last stage on a clock edge when the output is not stalled.
// One transaction can enter every cycle while o_stall is low; the eight register stages set the latency.
// Reset clears all stage valid bits and leaves the pipeline empty.
// A stalled result holds its stage, and earlier stages keep moving into empty slots.
// The request side stalls only when every stage holds a transaction.
module julian_day_number_converter
    import jdnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [13:0] i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [22:0] i_jdn_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [22:0] o_jdn_out,
    output logic [13:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic        o_invalid
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] stage_en;

    always_comb begin
        stage_en[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_stall = !stage_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: range checks and the first products.
    logic        early;
    logic [14:0] yb, yc;
    logic [22:0] jsum;

    logic        n_s1_req, n_s1_jok, n_s1_yok, n_s1_mok;
    logic [25:0] n_s1_p1;
    logic [27:0] n_s1_pc;
    logic [26:0] n_s1_py;
    logic [22:0] n_s1_a;
    logic [24:0] n_s1_x;
    logic [37:0] n_s1_px;

    always_comb begin
        early    = i_month_in <= MONTH_FEB;
        yb       = {1'b0, i_year_in} + 15'd4800 - 15'(early);
        yc       = {1'b0, i_year_in} + 15'd4900 - 15'(early);
        n_s1_req = i_req_type;
        n_s1_p1  = 26'(yb) * 26'd1461;
        n_s1_pc  = 28'(yc) * 28'(RECIP_100);
        n_s1_py  = 27'(i_year_in) * 27'(RECIP_100);
        n_s1_yok = i_year_in <= YEAR_MAX;
        n_s1_mok = (i_month_in >= MONTH_JAN) && (i_month_in <= MONTH_DEC);
        n_s1_jok = (i_jdn_in >= JDN_MIN) && (i_jdn_in <= JDN_MAX);
        n_s1_a   = i_jdn_in + 23'd32045;
        jsum     = i_jdn_in + 23'd68569;
        n_s1_x   = {jsum[22:0], 2'b00};
        n_s1_px  = 38'(n_s1_x) * 38'(RECIP_146097);
    end

    logic        r_s1_req, r_s1_jok, r_s1_yok, r_s1_mok;
    logic [13:0] r_s1_year;
    logic [3:0]  r_s1_month;
    logic [4:0]  r_s1_day;
    logic [25:0] r_s1_p1;
    logic [27:0] r_s1_pc;
    logic [26:0] r_s1_py;
    logic [22:0] r_s1_a;
    logic [24:0] r_s1_x;
    logic [37:0] r_s1_px;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1_req   <= n_s1_req;
            r_s1_jok   <= n_s1_jok;
            r_s1_yok   <= n_s1_yok;
            r_s1_mok   <= n_s1_mok;
            r_s1_year  <= i_year_in;
            r_s1_month <= i_month_in;
            r_s1_day   <= i_day_in;
            r_s1_p1    <= n_s1_p1;
            r_s1_pc    <= n_s1_pc;
            r_s1_py    <= n_s1_py;
            r_s1_a     <= n_s1_a;
            r_s1_x     <= n_s1_x;
            r_s1_px    <= n_s1_px;
        end
    end

    // Stage 2: leap year and day checks, formula terms, first quotient estimate.
    logic [8:0]  c100;
    logic [10:0] c100x3;
    logic [7:0]  qy;
    logic [14:0] hy;
    logic [13:0] r100;
    logic        leap;
    logic [4:0]  mlen;
    logic [24:0] qprod, qrem;

    logic        n_s2_dok;
    logic [23:0] n_s2_t1;
    logic [8:0]  n_s2_t2, n_s2_t3;
    logic [7:0]  n_s2_q0;
    logic [18:0] n_s2_rem;

    always_comb begin
        c100     = r_s1_pc[SHIFT_100 +: 9];
        c100x3   = {2'b00, c100} + {1'b0, c100, 1'b0};
        qy       = r_s1_py[SHIFT_100 +: 8];
        hy       = 15'(qy) * 15'd100;
        r100     = r_s1_year - hy[13:0];
        leap     = (r_s1_year[1:0] == 2'b00) && ((r100 != 14'd0) || (qy[1:0] == 2'b00));
        mlen     = month_length(r_s1_month, leap);
        n_s2_dok = r_s1_yok && r_s1_mok && (r_s1_day != 5'd0) && (r_s1_day <= mlen);
        n_s2_t1  = r_s1_p1[25:2];
        n_s2_t2  = month_offset(r_s1_month);
        n_s2_t3  = c100x3[10:2];
        n_s2_q0  = r_s1_px[SHIFT_146097 +: 8];
        qprod    = 25'(n_s2_q0) * 25'd146097;
        qrem     = r_s1_x - qprod;
        n_s2_rem = qrem[18:0];
    end

    logic        r_s2_req, r_s2_jok, r_s2_dok;
    logic [4:0]  r_s2_day;
    logic [23:0] r_s2_t1;
    logic [8:0]  r_s2_t2, r_s2_t3;
    logic [7:0]  r_s2_q0;
    logic [18:0] r_s2_rem;
    logic [22:0] r_s2_a;

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_s2_req <= r_s1_req;
            r_s2_jok <= r_s1_jok;
            r_s2_dok <= n_s2_dok;
            r_s2_day <= r_s1_day;
            r_s2_t1  <= n_s2_t1;
            r_s2_t2  <= n_s2_t2;
            r_s2_t3  <= n_s2_t3;
            r_s2_q0  <= n_s2_q0;
            r_s2_rem <= n_s2_rem;
            r_s2_a   <= r_s1_a;
        end
    end

    // Stage 3: day number sum and the four-century count with its remainder.
    logic [23:0] jdn_sum;
    logic [24:0] bprod;
    logic [22:0] cdiff;
    t_carry      n_s3_carry;
    logic [7:0]  n_s3_b;
    logic [15:0] n_s3_c;

    always_comb begin
        jdn_sum          = 24'(r_s2_day) + r_s2_t1 + 24'(r_s2_t2) - 24'(r_s2_t3) - 24'd32075;
        n_s3_b           = r_s2_q0 + 8'(r_s2_rem >= 19'd146097) - 8'd1;
        bprod            = 25'(n_s3_b) * 25'd146097;
        cdiff            = r_s2_a - bprod[24:2];
        n_s3_c           = cdiff[15:0];
        n_s3_carry.req   = r_s2_req;
        n_s3_carry.bad   = (r_s2_req == REQ_JDN_TO_DATE) ? !r_s2_jok : !r_s2_dok;
        n_s3_carry.jdn   = jdn_sum[22:0];
    end

    t_carry      r_s3_carry;
    logic [7:0]  r_s3_b;
    logic [15:0] r_s3_c;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_s3_carry <= n_s3_carry;
            r_s3_b     <= n_s3_b;
            r_s3_c     <= n_s3_c;
        end
    end

    // Stage 4: year-in-cycle quotient estimate.
    logic [15:0] cpl;
    logic [17:0] n_s4_x2;
    logic [27:0] n_s4_p2;

    always_comb begin
        cpl     = r_s3_c + 16'd365;
        n_s4_x2 = {cpl, 2'b00};
        n_s4_p2 = 28'(n_s4_x2) * 28'(RECIP_1461);
    end

    t_carry      r_s4_carry;
    logic [7:0]  r_s4_b;
    logic [15:0] r_s4_c;
    logic [17:0] r_s4_x2;
    logic [27:0] r_s4_p2;

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_s4_carry <= r_s3_carry;
            r_s4_b     <= r_s3_b;
            r_s4_c     <= r_s3_c;
            r_s4_x2    <= n_s4_x2;
            r_s4_p2    <= n_s4_p2;
        end
    end

    // Stage 5: remainder of the year estimate.
    logic [7:0]  n_s5_q0;
    logic [17:0] yprod, yrem;
    logic [11:0] n_s5_rem;

    always_comb begin
        n_s5_q0  = r_s4_p2[SHIFT_1461 +: 8];
        yprod    = 18'(n_s5_q0) * 18'd1461;
        yrem     = r_s4_x2 - yprod;
        n_s5_rem = yrem[11:0];
    end

    t_carry      r_s5_carry;
    logic [7:0]  r_s5_b;
    logic [15:0] r_s5_c;
    logic [7:0]  r_s5_q0;
    logic [11:0] r_s5_rem;

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_s5_carry <= r_s4_carry;
            r_s5_b     <= r_s4_b;
            r_s5_c     <= r_s4_c;
            r_s5_q0    <= n_s5_q0;
            r_s5_rem   <= n_s5_rem;
        end
    end

    // Stage 6: year within the century and day within the year.
    logic [7:0]  dd_full;
    logic [17:0] dprod;
    logic [15:0] ediff;
    logic [6:0]  n_s6_dd;
    logic [8:0]  n_s6_e;

    always_comb begin
        dd_full = r_s5_q0 + 8'(r_s5_rem >= 12'd1461) - 8'd1;
        n_s6_dd = dd_full[6:0];
        dprod   = 18'(n_s6_dd) * 18'd1461;
        ediff   = r_s5_c - dprod[17:2];
        n_s6_e  = ediff[8:0];
    end

    t_carry      r_s6_carry;
    logic [7:0]  r_s6_b;
    logic [6:0]  r_s6_dd;
    logic [8:0]  r_s6_e;

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_s6_carry <= r_s5_carry;
            r_s6_b     <= r_s5_b;
            r_s6_dd    <= n_s6_dd;
            r_s6_e     <= n_s6_e;
        end
    end

    // Stage 7: month index counted from March.
    logic [8:0]  em1;
    logic [10:0] x3;
    logic [23:0] mprod;
    logic [3:0]  n_s7_mm;

    always_comb begin
        em1     = r_s6_e - 9'd1;
        x3      = {em1, 2'b00} + 11'(em1) + 11'd2;
        mprod   = 24'(x3) * 24'(RECIP_153);
        n_s7_mm = mprod[SHIFT_153 +: 4];
    end

    t_carry      r_s7_carry;
    logic [7:0]  r_s7_b;
    logic [6:0]  r_s7_dd;
    logic [8:0]  r_s7_e;
    logic [3:0]  r_s7_mm;

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r_s7_carry <= r_s6_carry;
            r_s7_b     <= r_s6_b;
            r_s7_dd    <= r_s6_dd;
            r_s7_e     <= r_s6_e;
            r_s7_mm    <= n_s7_mm;
        end
    end

    // Stage 8: calendar fields and the output register.
    logic        late;
    logic [14:0] year_sum;
    logic [8:0]  dsum;
    logic [22:0] n_s8_jdn;
    logic [13:0] n_s8_year;
    logic [3:0]  n_s8_month;
    logic [4:0]  n_s8_day;

    always_comb begin
        late       = r_s7_mm >= 4'd10;
        year_sum   = 15'(r_s7_b) * 15'd100 + 15'(r_s7_dd) + 15'(late) - 15'd4800;
        dsum       = r_s7_e - day_offset(r_s7_mm);
        n_s8_jdn   = '0;
        n_s8_year  = '0;
        n_s8_month = '0;
        n_s8_day   = '0;
        if (!r_s7_carry.bad) begin
            if (r_s7_carry.req == REQ_DATE_TO_JDN) begin
                n_s8_jdn = r_s7_carry.jdn;
            end else begin
                n_s8_year  = year_sum[13:0];
                n_s8_month = late ? (r_s7_mm - 4'd9) : (r_s7_mm + 4'd3);
                n_s8_day   = dsum[4:0];
            end
        end
    end

    logic [22:0] r_s8_jdn;
    logic [13:0] r_s8_year;
    logic [3:0]  r_s8_month;
    logic [4:0]  r_s8_day;
    logic        r_s8_bad;

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            r_s8_jdn   <= n_s8_jdn;
            r_s8_year  <= n_s8_year;
            r_s8_month <= n_s8_month;
            r_s8_day   <= n_s8_day;
            r_s8_bad   <= r_s7_carry.bad;
        end
    end

    assign o_valid     = r_vld[STAGES-1];
    assign o_jdn_out   = r_s8_jdn;
    assign o_year_out  = r_s8_year;
    assign o_month_out = r_s8_month;
    assign o_day_out   = r_s8_day;
    assign o_invalid   = r_s8_bad;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_jdn_out == 23'd0 && o_year_out == 14'd0 &&
                                    o_month_out == 4'd0 && o_day_out == 5'd0))
        else $error("Invalid result carries nonzero fields.");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invalid) |-> ((o_month_out == 4'd0) ^ (o_jdn_out == 23'd0)))
        else $error("Valid result is neither a day number nor a date.");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invalid && o_month_out != 4'd0) |->
            (o_month_out <= MONTH_DEC && o_day_out != 5'd0 && o_year_out <= YEAR_MAX))
        else $error("Computed date is out of range.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("Request side stalled while the pipeline has an empty stage.");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("Accepted transaction did not enter the first stage.");
`endif

endmodule
